>>> sv/qru_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and product term tables for the quaternion rotate unit
package qru_pkg;

   // default component width, two's complement with FRAC_BITS fraction bits
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS          = 16;

   // added to a negative product before the arithmetic shift so it rounds toward zero
   localparam int RND_BIAS = (1 << FRAC_BITS) - 1;

   typedef enum logic {
      FUNC_PRODUCT = 1'b0,
      FUNC_ROTATE  = 1'b1
   } func_type;

   typedef logic [1:0] comp_idx_type;

   localparam comp_idx_type COMP_W = 2'd0;

   // hamilton product: component k = sum over n of +/- a[n] * b[TERM_B[k][n]]
   localparam comp_idx_type TERM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam logic TERM_NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

endpackage

>>> sv/qru_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the request and response items
interface qru_req_if #(
   parameter int DATA_WIDTH = qru_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] q_w;
   logic signed [DATA_WIDTH-1:0] q_x;
   logic signed [DATA_WIDTH-1:0] q_y;
   logic signed [DATA_WIDTH-1:0] q_z;
   logic signed [DATA_WIDTH-1:0] p_w;
   logic signed [DATA_WIDTH-1:0] p_x;
   logic signed [DATA_WIDTH-1:0] p_y;
   logic signed [DATA_WIDTH-1:0] p_z;

   modport source (
      output valid, func, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z,
      input  ready
   );
   modport sink (
      input  valid, func, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z,
      output ready
   );
   modport monitor (
      input valid, ready, func, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z
   );
endinterface

interface qru_rsp_if #(
   parameter int DATA_WIDTH = qru_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r_w;
   logic signed [DATA_WIDTH-1:0] r_x;
   logic signed [DATA_WIDTH-1:0] r_y;
   logic signed [DATA_WIDTH-1:0] r_z;
   logic                         saturated;

   modport source (
      output valid, r_w, r_x, r_y, r_z, saturated,
      input  ready
   );
   modport sink (
      input  valid, r_w, r_x, r_y, r_z, saturated,
      output ready
   );
   modport monitor (
      input valid, ready, r_w, r_x, r_y, r_z, saturated
   );
endinterface

>>> sv/quaternion_rotate_unit_core.sv
`timescale 1ns / 1ps
// quaternion product and vector rotation pipeline, signed fixed point with 16 fraction bits
//
// usage
//   req_chan carries one item: func, quaternion q and quaternion p (or vector p_x..p_z).
//   func = product gives q*p; func = rotate gives the vector part of q*v*conj(q), r_w = 0.
//   rsp_chan returns one item per request with the four components and a saturated flag.
// pipeline and throughput
//   seven register stages plus the output register. one item enters every cycle while the
//   skid register is empty; the 16-wide multiplier bank of each pass and the 4-way adders
//   set the stage split, not any loop.
//   the second pass cuts each product into a low and a high partial product that are
//   registered and then summed, so no single multiplier is wider than data width by
//   data width plus one.
// stalls
//   an output register plus a skid register sit at the end; all stages advance together
//   whenever the skid register is empty. when the receiver holds off, the item leaving
//   the pipeline lands in the skid register and req_chan.ready drops the next cycle.
// reset
//   synchronous, clears all valid bits, output and skid; payload registers are not reset.
module quaternion_rotate_unit_core #(
   parameter int DATA_WIDTH = qru_pkg::DATA_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   qru_req_if.sink    req_chan,
   qru_rsp_if.source  rsp_chan
);

   localparam int W    = DATA_WIDTH;
   localparam int FB   = qru_pkg::FRAC_BITS;
   localparam int PW   = 2 * W;        // first pass raw product
   localparam int P    = PW - FB;      // first pass rounded product
   localparam int T    = P + 2;        // intermediate quaternion component
   localparam int LW   = 2 * W + 1;    // low partial product of second pass
   localparam int M    = T + W;        // full second pass product
   localparam int P2   = M - FB;       // second pass rounded product
   localparam int R    = P2 + 2;       // rotated component before clipping
   localparam int NSTG = 7;

   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic signed [W-1:0] r_w;
      logic signed [W-1:0] r_x;
      logic signed [W-1:0] r_y;
      logic signed [W-1:0] r_z;
      logic                saturated;
   } rsp_payload_type;

   // global advance: every stage moves while the skid register is free
   logic en;
   logic accept;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;

   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   // valid and mode bits travel with the data
   logic [NSTG-1:0] valid_ff, valid_in;
   logic [NSTG-1:0] rot_ff, rot_in;
   logic            req_rot;

   assign req_rot  = (req_chan.func == qru_pkg::FUNC_ROTATE);
   assign valid_in = {valid_ff[NSTG-2:0], accept};
   assign rot_in   = {rot_ff[NSTG-2:0], req_rot};

   // stage 1: first pass products, q times p (p_w forced to zero when rotating)
   logic signed [W-1:0]  qa [4];
   logic signed [W-1:0]  pb [4];
   logic signed [PW-1:0] prod_in [4][4];
   logic signed [PW-1:0] prod_ff [4][4];
   logic signed [W-1:0]  q1_ff [4];
   logic signed [W-1:0]  q2_ff [4];
   logic signed [W-1:0]  q3_ff [4];

   always_comb begin
      qa[0] = req_chan.q_w;
      qa[1] = req_chan.q_x;
      qa[2] = req_chan.q_y;
      qa[3] = req_chan.q_z;
      pb[0] = req_rot ? '0 : req_chan.p_w;
      pb[1] = req_chan.p_x;
      pb[2] = req_chan.p_y;
      pb[3] = req_chan.p_z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = PW'(qa[i]) * PW'(pb[j]);
         end
      end
   end

   // stage 2: drop fraction bits, rounding toward zero
   logic signed [PW-1:0] adj1 [4][4];
   logic signed [P-1:0]  rnd_in [4][4];
   logic signed [P-1:0]  rnd_ff [4][4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            adj1[i][j]   = prod_ff[i][j]
                         + (prod_ff[i][j][PW-1] ? PW'(qru_pkg::RND_BIAS) : PW'(0));
            rnd_in[i][j] = adj1[i][j][PW-1:FB];
         end
      end
   end

   // stage 3: hamilton sums, full width, no clipping
   logic signed [T-1:0] t_in [4];
   logic signed [T-1:0] t_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         t_in[k] = '0;
         for (int n = 0; n < 4; n++) begin
            if (qru_pkg::TERM_NEG[k][n]) begin
               t_in[k] = t_in[k] - T'(rnd_ff[n][qru_pkg::TERM_B[k][n]]);
            end else begin
               t_in[k] = t_in[k] + T'(rnd_ff[n][qru_pkg::TERM_B[k][n]]);
            end
         end
      end
   end

   // stage 4: second pass, t times q split into low and high partial products
   // conj(q) is folded into the signs of the final sum
   logic signed [LW-1:0] pp_lo_in [4][4];
   logic signed [LW-1:0] pp_lo_ff [4][4];
   logic signed [T-1:0]  pp_hi_in [4][4];
   logic signed [T-1:0]  pp_hi_ff [4][4];
   logic signed [T-1:0]  t4_ff [4];
   logic signed [T-1:0]  t5_ff [4];
   logic signed [T-1:0]  t6_ff [4];
   logic signed [T-1:0]  t7_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_lo_in[i][j] = LW'($signed({1'b0, t_ff[i][W-1:0]})) * LW'(q3_ff[j]);
            pp_hi_in[i][j] = T'($signed(t_ff[i][T-1:W])) * T'(q3_ff[j]);
         end
      end
   end

   // stage 5: recombine partial products
   logic signed [M-1:0] full_in [4][4];
   logic signed [M-1:0] full_ff [4][4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            full_in[i][j] = (M'(pp_hi_ff[i][j]) <<< W) + M'(pp_lo_ff[i][j]);
         end
      end
   end

   // stage 6: second pass rounding toward zero
   logic signed [M-1:0]  adj2 [4][4];
   logic signed [P2-1:0] rnd2_in [4][4];
   logic signed [P2-1:0] rnd2_ff [4][4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            adj2[i][j]    = full_ff[i][j]
                          + (full_ff[i][j][M-1] ? M'(qru_pkg::RND_BIAS) : M'(0));
            rnd2_in[i][j] = adj2[i][j][M-1:FB];
         end
      end
   end

   // stage 7: second hamilton sums against conj(q): every non-real q term flips sign
   logic signed [R-1:0] r_in [4];
   logic signed [R-1:0] r_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r_in[k] = '0;
         for (int n = 0; n < 4; n++) begin
            if (qru_pkg::TERM_NEG[k][n]
                ^ (qru_pkg::TERM_B[k][n] != qru_pkg::COMP_W)) begin
               r_in[k] = r_in[k] - R'(rnd2_ff[n][qru_pkg::TERM_B[k][n]]);
            end else begin
               r_in[k] = r_in[k] + R'(rnd2_ff[n][qru_pkg::TERM_B[k][n]]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         q1_ff    <= qa;
         rnd_ff   <= rnd_in;
         q2_ff    <= q1_ff;
         t_ff     <= t_in;
         q3_ff    <= q2_ff;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         t4_ff    <= t_ff;
         full_ff  <= full_in;
         t5_ff    <= t4_ff;
         rnd2_ff  <= rnd2_in;
         t6_ff    <= t5_ff;
         r_ff     <= r_in;
         t7_ff    <= t6_ff;
         rot_ff   <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // final select and clip to data width; rotate mode drops the real part
   logic signed [R-1:0] sel [4];
   logic [R-W:0]        upper [4];
   logic signed [W-1:0] comp [4];
   logic [3:0]          clip;
   rsp_payload_type     res_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sel[k]   = rot_ff[NSTG-1] ? r_ff[k] : R'(t7_ff[k]);
         upper[k] = sel[k][R-1:W-1];
         clip[k]  = !((&upper[k]) || !(|upper[k]));
         if (clip[k]) begin
            comp[k] = sel[k][R-1] ? MINV : MAXV;
         end else begin
            comp[k] = sel[k][W-1:0];
         end
      end
      if (rot_ff[NSTG-1]) begin
         comp[0] = '0;
         clip[0] = 1'b0;
      end
      res_in.r_w       = comp[0];
      res_in.r_x       = comp[1];
      res_in.r_y       = comp[2];
      res_in.r_z       = comp[3];
      res_in.saturated = |clip;
   end

   // output register with skid register behind it
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // pipeline frozen, drain the parked item
         if (rsp_chan.ready) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (valid_ff[NSTG-1]) begin
         if (out_valid_ff && !rsp_chan.ready) begin
            skid_in       = res_in;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res_in;
            out_valid_in = 1'b1;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.r_w       = out_ff.r_w;
   assign rsp_chan.r_x       = out_ff.r_x;
   assign rsp_chan.r_y       = out_ff.r_y;
   assign rsp_chan.r_z       = out_ff.r_z;
   assign rsp_chan.saturated = out_ff.saturated;

endmodule

>>> sv/qru_checker.sv
`timescale 1ns / 1ps
// port-level checks for the quaternion rotate unit and their bind to the top level
module qru_checker #(
   parameter int DATA_WIDTH = qru_pkg::DATA_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_r_w,
   input logic [DATA_WIDTH-1:0] rsp_r_x,
   input logic [DATA_WIDTH-1:0] rsp_r_y,
   input logic [DATA_WIDTH-1:0] rsp_r_z,
   input logic                  rsp_saturated
);

   // reset empties the output and skid registers
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("qru: not empty after reset");

   // a stalled item holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_r_w) && $stable(rsp_r_x)
         && $stable(rsp_r_y) && $stable(rsp_r_z)
         && $stable(rsp_saturated))
      else $error("qru: stalled item changed");

   // requests are held off only while an item waits at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("qru: request stalled with empty output");

   // ready drops only after the receiver refused an item
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("qru: request stall without output stall");

endmodule

bind quaternion_rotate_unit_core qru_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qru_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_r_w       (rsp_chan.r_w),
   .rsp_r_x       (rsp_chan.r_x),
   .rsp_r_y       (rsp_chan.r_y),
   .rsp_r_z       (rsp_chan.r_z),
   .rsp_saturated (rsp_chan.saturated)
);

>>> bench/quaternion_rotate_unit_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the quaternion product and vector rotation core
module quaternion_rotate_unit_core_test;

   localparam int DW           = qru_pkg::DATA_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 40;      // pipeline is 8 deep plus skid, this is plenty
   localparam int MAX_PRINTED  = 40;
   localparam int TIMEOUT_NS   = 1000000;
   localparam int ONE_I        = 1 << qru_pkg::FRAC_BITS;

   // prediction runs at 128 bits: a rotation's second pass needs about 84
   typedef logic signed [127:0]  wide_type;
   typedef logic signed [DW-1:0] comp_type;

   localparam wide_type POS_LIMIT = (wide_type'(1) <<< (DW - 1)) - wide_type'(1);
   localparam wide_type NEG_LIMIT = -(wide_type'(1) <<< (DW - 1));

   localparam comp_type MAX_C    = {1'b0, {(DW - 1){1'b1}}};
   localparam comp_type MIN_C    = {1'b1, {(DW - 1){1'b0}}};
   localparam comp_type ALL_ONES = '1;
   localparam comp_type ONE      = comp_type'(ONE_I);
   localparam comp_type COS_45   = comp_type'(46341);   // cos(pi/4) in 16 fraction bits
   localparam comp_type ALT_A    = {(DW / 2){2'b10}};
   localparam comp_type ALT_5    = {(DW / 2){2'b01}};

   typedef struct packed {
      qru_pkg::func_type func;
      comp_type          q_w, q_x, q_y, q_z;
      comp_type          p_w, p_x, p_y, p_z;
   } request_type;

   typedef struct packed {
      comp_type r_w, r_x, r_y, r_z;
      logic     saturated;
   } result_type;

   typedef struct packed {
      wide_type w, x, y, z;
   } wquat_type;

   // shapes of random component values
   typedef enum {KIND_FULL, KIND_UNIT, KIND_MODERATE, KIND_EDGE, KIND_ANY} value_kind_type;

   // receiver behavior over one stretch of cycles
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN, STALL_HOLD}
      stall_mode_type;

   class qru_scoreboard;
      result_type expected_results[$];
      int         mismatches;
      int         checked;
      int         products;
      int         rotations;
      int         clipped;

      function new();
         mismatches = 0;
         checked    = 0;
         products   = 0;
         rotations  = 0;
         clipped    = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function wide_type widen(comp_type v);
         wide_type r;
         r = v;
         return r;
      endfunction

      // product of two fixed-point values, shifted back and truncated toward zero
      function wide_type fx_mul(wide_type a, wide_type b);
         wide_type prod;
         prod = a * b;
         if (prod < 0) return -((-prod) >>> qru_pkg::FRAC_BITS);
         return prod >>> qru_pkg::FRAC_BITS;
      endfunction

      function wquat_type hamilton(wquat_type a, wquat_type b);
         wquat_type r;
         r.w = fx_mul(a.w, b.w) - fx_mul(a.x, b.x) - fx_mul(a.y, b.y) - fx_mul(a.z, b.z);
         r.x = fx_mul(a.w, b.x) + fx_mul(a.x, b.w) + fx_mul(a.y, b.z) - fx_mul(a.z, b.y);
         r.y = fx_mul(a.w, b.y) - fx_mul(a.x, b.z) + fx_mul(a.y, b.w) + fx_mul(a.z, b.x);
         r.z = fx_mul(a.w, b.z) + fx_mul(a.x, b.y) - fx_mul(a.y, b.x) + fx_mul(a.z, b.w);
         return r;
      endfunction

      function comp_type clip(wide_type v, inout bit hit);
         if (v > POS_LIMIT) begin
            hit = 1'b1;
            return comp_type'(POS_LIMIT);
         end
         if (v < NEG_LIMIT) begin
            hit = 1'b1;
            return comp_type'(NEG_LIMIT);
         end
         return comp_type'(v);
      endfunction

      // work out the result of one accepted request and queue it
      function void note_request(request_type it);
         wquat_type  q, p, t, c, r;
         result_type e;
         bit         hit;
         hit = 1'b0;
         q.w = widen(it.q_w);
         q.x = widen(it.q_x);
         q.y = widen(it.q_y);
         q.z = widen(it.q_z);
         p.w = widen(it.p_w);
         p.x = widen(it.p_x);
         p.y = widen(it.p_y);
         p.z = widen(it.p_z);
         if (it.func == qru_pkg::FUNC_ROTATE) begin
            // v has no real part; the real part of the outcome is dropped entirely
            p.w = '0;
            c.w = q.w;
            c.x = -q.x;
            c.y = -q.y;
            c.z = -q.z;
            t = hamilton(q, p);
            r = hamilton(t, c);
            e.r_w = '0;
            rotations++;
         end else begin
            r = hamilton(q, p);
            e.r_w = clip(r.w, hit);
            products++;
         end
         e.r_x = clip(r.x, hit);
         e.r_y = clip(r.y, hit);
         e.r_z = clip(r.z, hit);
         e.saturated = hit;
         if (hit) clipped++;
         expected_results = {expected_results, e};
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_response(result_type got);
         result_type e;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no request pending (r_w %0d)", got.r_w));
            return;
         end
         e = expected_results.pop_front();
         if (got.r_w !== e.r_w)
            report_mismatch($sformatf("result %0d r_w %0d, want %0d", checked, got.r_w, e.r_w));
         if (got.r_x !== e.r_x)
            report_mismatch($sformatf("result %0d r_x %0d, want %0d", checked, got.r_x, e.r_x));
         if (got.r_y !== e.r_y)
            report_mismatch($sformatf("result %0d r_y %0d, want %0d", checked, got.r_y, e.r_y));
         if (got.r_z !== e.r_z)
            report_mismatch($sformatf("result %0d r_z %0d, want %0d", checked, got.r_z, e.r_z));
         if (got.saturated !== e.saturated)
            report_mismatch($sformatf("result %0d saturated %b, want %b",
                                      checked, got.saturated, e.saturated));
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   qru_req_if #(.DATA_WIDTH(DW)) req_chan ();
   qru_rsp_if #(.DATA_WIDTH(DW)) rsp_chan ();

   qru_scoreboard board = new();

   quaternion_rotate_unit_core #(.DATA_WIDTH(DW)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // input monitor: every accepted item gets its prediction queued
   always @(posedge clock) begin : watch_requests
      request_type seen;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen.func = qru_pkg::func_type'(req_chan.func);
         seen.q_w  = req_chan.q_w;
         seen.q_x  = req_chan.q_x;
         seen.q_y  = req_chan.q_y;
         seen.q_z  = req_chan.q_z;
         seen.p_w  = req_chan.p_w;
         seen.p_x  = req_chan.p_x;
         seen.p_y  = req_chan.p_y;
         seen.p_z  = req_chan.p_z;
         board.note_request(seen);
      end
   end

   // output monitor: every accepted result is checked against the oldest prediction
   always @(posedge clock) begin : watch_results
      result_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.r_w       = rsp_chan.r_w;
         seen.r_x       = rsp_chan.r_x;
         seen.r_y       = rsp_chan.r_y;
         seen.r_z       = rsp_chan.r_z;
         seen.saturated = rsp_chan.saturated;
         board.check_response(seen);
      end
   end

   // receiver: stretches of free flow, light and heavy random stalls,
   // a rotating bit pattern, and solid hold-offs that back up the skid register
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             span;
      logic [15:0]    pattern;
      rsp_chan.ready = 1'b0;
      forever begin
         mode    = stall_mode_type'($urandom_range(0, 4));
         span    = (mode == STALL_HOLD) ? $urandom_range(3, 20) : $urandom_range(8, 80);
         pattern = 16'($urandom);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:    rsp_chan.ready <= 1'b1;
               STALL_LIGHT:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:   rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               STALL_PATTERN: begin
                  rsp_chan.ready <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
               default:       rsp_chan.ready <= 1'b0;
            endcase
         end
      end
   end

   function automatic comp_type random_comp(value_kind_type kind);
      value_kind_type pick;
      pick = kind;
      if (pick == KIND_ANY) pick = value_kind_type'($urandom_range(0, 3));
      case (pick)
         KIND_UNIT:     return comp_type'(int'($urandom_range(0, 2 * ONE_I)) - ONE_I);
         KIND_MODERATE: return comp_type'(int'($urandom_range(0, 16 * ONE_I)) - 8 * ONE_I);
         KIND_EDGE: begin
            case ($urandom_range(0, 7))
               0:       return MIN_C;
               1:       return MAX_C;
               2:       return '0;
               3:       return ALL_ONES;
               4:       return comp_type'(1);
               5:       return ONE;
               6:       return -ONE;
               default: return comp_type'(1) << $urandom_range(0, DW - 1);
            endcase
         end
         default:       return comp_type'($urandom);
      endcase
   endfunction

   function automatic request_type make_request(qru_pkg::func_type f, comp_type qw,
                                                comp_type qx, comp_type qy, comp_type qz,
                                                comp_type pw, comp_type px, comp_type py,
                                                comp_type pz);
      request_type it;
      it.func = f;
      it.q_w  = qw;
      it.q_x  = qx;
      it.q_y  = qy;
      it.q_z  = qz;
      it.p_w  = pw;
      it.p_x  = px;
      it.p_y  = py;
      it.p_z  = pz;
      return it;
   endfunction

   // offer one item at the falling edge and hold it until the core takes it
   task automatic send_request(request_type it);
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.func  <= it.func;
      req_chan.q_w   <= it.q_w;
      req_chan.q_x   <= it.q_x;
      req_chan.q_y   <= it.q_y;
      req_chan.q_z   <= it.q_z;
      req_chan.p_w   <= it.p_w;
      req_chan.p_x   <= it.p_x;
      req_chan.p_y   <= it.p_y;
      req_chan.p_z   <= it.p_z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   initial begin : main_sequence
      int             sent;
      int             burst;
      int             gap;
      int             shape;
      value_kind_type qk;
      value_kind_type pk;
      request_type    item;

      req_chan.valid = 1'b0;
      req_chan.func  = qru_pkg::FUNC_PRODUCT;
      req_chan.q_w   = '0;
      req_chan.q_x   = '0;
      req_chan.q_y   = '0;
      req_chan.q_z   = '0;
      req_chan.p_w   = '0;
      req_chan.p_x   = '0;
      req_chan.p_y   = '0;
      req_chan.p_z   = '0;

      // synchronous reset held from the start, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed products: zero, identity, basis units, clipping both ways,
      // truncation of negative products toward zero, dense bit patterns
      send_request(make_request(qru_pkg::FUNC_PRODUCT, '0, '0, '0, '0, '0, '0, '0, '0));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, ONE, '0, '0, '0,
                                comp_type'(98304), comp_type'(-147456), comp_type'(196608),
                                comp_type'(-32768)));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, '0, ONE, '0, '0, '0, '0, ONE, '0));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, MAX_C, MAX_C, MAX_C, MAX_C,
                                MAX_C, MAX_C, MAX_C, MAX_C));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, MIN_C, MIN_C, MIN_C, MIN_C,
                                MIN_C, MIN_C, MIN_C, MIN_C));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, MAX_C, MAX_C, MAX_C, MAX_C,
                                MIN_C, MIN_C, MIN_C, MIN_C));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, comp_type'(-3), comp_type'(-1),
                                comp_type'(5), comp_type'(7), comp_type'(32768),
                                comp_type'(1), comp_type'(-65535), comp_type'(-9363)));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, ALL_ONES, ALL_ONES, ALL_ONES,
                                ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, ALT_A, ALT_5, ALT_A, ALT_5,
                                ALT_5, ALT_A, ALT_5, ALT_A));
      send_request(make_request(qru_pkg::FUNC_PRODUCT, comp_type'(1), comp_type'(2),
                                MIN_C, MAX_C, MAX_C, MIN_C, comp_type'(-2),
                                comp_type'(-1)));
      idle_sender(3);

      // directed rotations: identity with a junk real part, quarter and half turns,
      // a non-unit quaternion that scales, clipping, and the real part always dropped
      send_request(make_request(qru_pkg::FUNC_ROTATE, ONE, '0, '0, '0,
                                MAX_C, ONE, 2 * ONE, 3 * ONE));
      send_request(make_request(qru_pkg::FUNC_ROTATE, COS_45, '0, '0, COS_45,
                                '0, ONE, '0, '0));
      send_request(make_request(qru_pkg::FUNC_ROTATE, '0, ONE, '0, '0,
                                MIN_C, ONE, ONE, ONE));
      send_request(make_request(qru_pkg::FUNC_ROTATE, 2 * ONE, '0, '0, '0,
                                ALL_ONES, ONE, -ONE, 3 * ONE));
      send_request(make_request(qru_pkg::FUNC_ROTATE, MAX_C, MAX_C, MAX_C, MAX_C,
                                MAX_C, MAX_C, MAX_C, MAX_C));
      send_request(make_request(qru_pkg::FUNC_ROTATE, MIN_C, MIN_C, MIN_C, MIN_C,
                                MIN_C, MIN_C, MIN_C, MIN_C));
      send_request(make_request(qru_pkg::FUNC_ROTATE, ONE, ONE, ONE, ONE,
                                '0, MAX_C, MIN_C, MAX_C));
      send_request(make_request(qru_pkg::FUNC_ROTATE, ALL_ONES, ALL_ONES, ALL_ONES,
                                ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send_request(make_request(qru_pkg::FUNC_ROTATE, ALT_5, ALT_A, ALT_5, ALT_A,
                                ALT_A, ALT_5, ALT_A, ALT_5));
      send_request(make_request(qru_pkg::FUNC_ROTATE, '0, '0, '0, '0,
                                ALL_ONES, MAX_C, MIN_C, ONE));
      idle_sender(2);

      // random part: 45 percent well-formed operands (near-unit q, moderate p),
      // the rest full-range noise, mixed shapes and edge values
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 32);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            shape = $urandom_range(0, 99);
            if (shape < 45) begin
               qk = KIND_UNIT;
               pk = KIND_MODERATE;
            end else if (shape < 70) begin
               qk = KIND_FULL;
               pk = KIND_FULL;
            end else if (shape < 88) begin
               qk = KIND_ANY;
               pk = KIND_ANY;
            end else begin
               qk = KIND_EDGE;
               pk = KIND_EDGE;
            end
            item.func = qru_pkg::func_type'($urandom_range(0, 1));
            item.q_w  = random_comp(qk);
            item.q_x  = random_comp(qk);
            item.q_y  = random_comp(qk);
            item.q_z  = random_comp(qk);
            item.p_w  = random_comp(pk);
            item.p_x  = random_comp(pk);
            item.p_y  = random_comp(pk);
            item.p_z  = random_comp(pk);
            send_request(item);
            sent++;
         end
         // half the bursts run straight into the next one
         case ($urandom_range(0, 3))
            0:       gap = $urandom_range(1, 3);
            1:       gap = $urandom_range(4, 12);
            default: gap = 0;
         endcase
         idle_sender(gap);
      end
      idle_sender(1);

      // drain, then watch a while longer for any stray result
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d quaternion products and %0d vector rotations, %0d clipped",
               board.products, board.rotations, board.clipped);
      $display("bursty sender, varied receiver stalls; %0d results checked, %0d mismatches",
               board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hard stop well beyond the slowest legitimate run
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("watchdog expired with %0d results outstanding", board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
